// ===== rtl/lobm_pkg.sv =====
// Shared types and constants for the limit order book matcher.
`default_nettype none
package lobm_pkg;
  localparam int unsigned ORDER_SLOTS = 32;
  localparam int unsigned SLOT_W = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  // slot entry: side, price, quantity, order id, time, arrival
  localparam int unsigned ENTRY_W = 1 + 32 + 32 + 32 + 48 + 32;

  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  localparam logic [2:0] ST_FILLED    = 3'd0;
  localparam logic [2:0] ST_RESTED    = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_MKT_REF   = 3'd4;
  localparam logic [2:0] ST_BOOK_FULL = 3'd5;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] oid;
    logic [47:0] ts;
    logic [31:0] arr;
  } entry_t;
endpackage
`default_nettype wire

// ===== rtl/lobm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// Top level: price-time priority order book on a slot memory, scanned per step.
//
//  channel | dir | ports
//  in_     | in  | valid/ready, func, order_id, side, is_market, price, quantity, timestamp
//  out_    | out | valid/ready, kind, trade_id, buy/sell_order_id, trade_price, amount,
//          |     | trade_time, status, last
//
// One request at a time. Each best-price or id search walks all ORDER_SLOTS
// entries through the single RAM read port, one per cycle, and each trade
// passes through the fill and emit states before the search runs again.
// Valid bits sit in flops cleared by reset; no clearing pass. The engine waits
// while a result beat stalls in the output register.
`default_nettype none
module limit_order_book_matcher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_order_id,
  input  wire logic        in_side,
  input  wire logic        in_is_market,
  input  wire logic signed [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [47:0] in_timestamp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_trade_id,
  output logic [31:0]      out_buy_order_id,
  output logic [31:0]      out_sell_order_id,
  output logic signed [31:0] out_trade_price,
  output logic [31:0]      out_amount,
  output logic [47:0]      out_trade_time,
  output logic [2:0]       out_status,
  output logic             out_last
);
  localparam int unsigned SW = lobm_pkg::SLOT_W;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned ORDER_SLOTS_M1 = lobm_pkg::ORDER_SLOTS - 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010, // best opposite order search
    S_FILL   = 7'b0000100, // trade against chosen slot
    S_FIND   = 7'b0001000, // id search
    S_FOUND  = 7'b0010000, // act on found slot (read data ready)
    S_REST   = 7'b0100000,
    S_EMIT   = 7'b1000000  // wait for output register
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  // request registers
  logic [1:0]  func_r;
  logic [31:0] oid_r, price_r, qty_r;
  logic        side_r;
  logic [47:0] ts_r;

  logic [ORDER_SLOTS_M1:0] vld_r;
  logic [31:0] arrcnt_r, tradeno_r;

  // scan state
  logic [CW-1:0] cnt_r;
  logic          rd_vld_r;   // rdata corresponds to slot rd_idx_r
  logic [SW-1:0] rd_idx_r;
  logic          have_r;
  logic [SW-1:0] best_r;
  logic [31:0]   bprice_r, bage_r, bqty_r, boid_r;
  logic [47:0]   bts_r;

  // RAM
  logic          we;
  logic [SW-1:0] waddr, raddr;
  lobm_pkg::entry_t wdata, rdata;

  lobm_ram #(.WIDTH(lobm_pkg::ENTRY_W), .DEPTH(lobm_pkg::ORDER_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // output register
  logic        ov_r;
  logic        okind_r, olast_r;
  logic [31:0] otid_r, obuy_r, osell_r, oprice_r, oamt_r;
  logic [47:0] otime_r;
  logic [2:0]  ost_r;

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_trade_id = otid_r;
  assign out_buy_order_id = obuy_r;
  assign out_sell_order_id = osell_r;
  assign out_trade_price = oprice_r;
  assign out_amount = oamt_r;
  assign out_trade_time = otime_r;
  assign out_status = ost_r;
  assign out_last = olast_r;
  assign in_ready = (state_r == S_IDLE);

  // candidate compare on registered read data
  logic [31:0] ra, rb, age_rd;
  logic        opp_side, better, cand;
  always_comb begin
    opp_side = ~side_r;
    ra = rdata.price ^ 32'h8000_0000;
    rb = bprice_r ^ 32'h8000_0000;
    age_rd = arrcnt_r - rdata.arr;
    better = opp_side ? (ra < rb) : (ra > rb);
    if (state_r == S_SCAN)
      cand = rd_vld_r && vld_r[rd_idx_r] && (rdata.side == opp_side) &&
             (!have_r || better || (ra == rb && age_rd > bage_r));
    else
      cand = rd_vld_r && vld_r[rd_idx_r] && (rdata.oid == oid_r) &&
             (!have_r || age_rd < bage_r);
  end

  // first free slot (priority over valid bits)
  logic          free_any;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = lobm_pkg::ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // crossing check against chosen best and fill amount
  logic        crosses;
  logic [31:0] fill;
  always_comb begin
    crosses = side_r ? ((price_r ^ 32'h8000_0000) <= (bprice_r ^ 32'h8000_0000))
                     : ((price_r ^ 32'h8000_0000) >= (bprice_r ^ 32'h8000_0000));
    fill = (qty_r < bqty_r) ? qty_r : bqty_r;
  end

  // control and datapath
  logic        ld_out;
  logic        nk, nl;
  logic [31:0] ntid, nbuy, nsell, nprice, namt;
  logic [47:0] ntime;
  logic [2:0]  nst;
  logic [CW-1:0] cnt_nxt;
  logic scan_done;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    we = 1'b0;
    waddr = best_r;
    wdata = '0;
    raddr = cnt_r[SW-1:0];
    ld_out = 1'b0;
    nk = lobm_pkg::KIND_STATUS; nl = 1'b1;
    ntid = '0; nbuy = '0; nsell = '0; nprice = '0; namt = '0; ntime = '0;
    nst = lobm_pkg::ST_NOT_FOUND;
    cnt_nxt = cnt_r;
    scan_done = (cnt_r == CW'(lobm_pkg::ORDER_SLOTS)) && rd_vld_r &&
                (rd_idx_r == SW'(lobm_pkg::ORDER_SLOTS - 1));
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          if (in_func == lobm_pkg::FUNC_SUBMIT && !in_is_market) begin
            state_nxt = S_SCAN;
          end else if (in_func == lobm_pkg::FUNC_CANCEL ||
                       in_func == lobm_pkg::FUNC_MODIFY) begin
            state_nxt = S_FIND;
          end else begin
            // market order or unused code: status right away
            ld_out = 1'b1;
            nst = (in_func == lobm_pkg::FUNC_SUBMIT) ? lobm_pkg::ST_MKT_REF
                                                     : lobm_pkg::ST_NOT_FOUND;
            state_nxt = S_EMIT;
            ret_nxt = S_IDLE;
          end
        end
      end
      S_SCAN, S_FIND: begin
        if (cnt_r < CW'(lobm_pkg::ORDER_SLOTS)) cnt_nxt = cnt_r + CW'(1);
        if (scan_done) begin
          state_nxt = (state_r == S_SCAN) ? S_FILL : S_FOUND;
        end
        raddr = (state_r == S_FIND && scan_done) ? (cand ? rd_idx_r : best_r)
                                                 : cnt_r[SW-1:0];
      end
      S_FOUND: begin
        // best_r data is on rdata now
        if (!have_r) begin
          ld_out = 1'b1; nst = lobm_pkg::ST_NOT_FOUND; state_nxt = S_EMIT;
          ret_nxt = S_IDLE;
        end else if (func_r == lobm_pkg::FUNC_CANCEL) begin
          ld_out = 1'b1; nst = lobm_pkg::ST_CANCELLED; state_nxt = S_EMIT;
          ret_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN; // resubmit; fields updated in sequential block
          cnt_nxt = '0;
        end
      end
      S_FILL: begin
        if (have_r && qty_r != 32'd0 && crosses) begin
          we = 1'b1;
          waddr = best_r;
          wdata.side = ~side_r;
          wdata.price = bprice_r;
          wdata.qty = bqty_r - fill;
          wdata.oid = boid_r;
          wdata.ts = bts_r;
          wdata.arr = arrcnt_r - bage_r;
          ld_out = 1'b1; nk = lobm_pkg::KIND_TRADE; nl = 1'b0;
          ntid = tradeno_r;
          nbuy = side_r ? boid_r : oid_r;
          nsell = side_r ? oid_r : boid_r;
          nprice = bprice_r; namt = fill; ntime = ts_r;
          nst = lobm_pkg::ST_FILLED;
          state_nxt = S_EMIT;
          ret_nxt = S_SCAN;
          cnt_nxt = '0;
        end else if (qty_r == 32'd0) begin
          ld_out = 1'b1; nst = lobm_pkg::ST_FILLED; state_nxt = S_EMIT; ret_nxt = S_IDLE;
        end else begin
          state_nxt = S_REST;
        end
      end
      S_REST: begin
        ld_out = 1'b1; namt = qty_r; ret_nxt = S_IDLE; state_nxt = S_EMIT;
        if (free_any) begin
          we = 1'b1;
          waddr = free_idx;
          wdata.side = side_r; wdata.price = price_r; wdata.qty = qty_r;
          wdata.oid = oid_r; wdata.ts = ts_r; wdata.arr = arrcnt_r;
          nst = lobm_pkg::ST_RESTED;
        end else begin
          nst = lobm_pkg::ST_BOOK_FULL;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_ready) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      vld_r <= '0;
      arrcnt_r <= '0;
      tradeno_r <= 32'd1;
      ov_r <= 1'b0;
      rd_vld_r <= 1'b0;
      have_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      cnt_r <= cnt_nxt;
      rd_vld_r <= (state_r == S_SCAN || state_r == S_FIND) &&
                  cnt_r < CW'(lobm_pkg::ORDER_SLOTS);
      ov_r <= ld_out | (ov_r & ~out_ready);
      case (state_r)
        S_IDLE: begin
          have_r <= 1'b0;
        end
        S_SCAN, S_FIND: begin
          if (cand) begin
            have_r <= 1'b1;
            best_r <= rd_idx_r;
            bprice_r <= rdata.price;
            bage_r <= age_rd;
            bqty_r <= rdata.qty;
            boid_r <= rdata.oid;
            bts_r <= rdata.ts;
          end
        end
        S_FOUND: begin
          have_r <= 1'b0;
          if (have_r) vld_r[best_r] <= 1'b0;
        end
        S_FILL: begin
          have_r <= 1'b0;
          if (we) begin
            tradeno_r <= tradeno_r + 32'd1;
            if (bqty_r == fill) vld_r[best_r] <= 1'b0;
          end
        end
        S_REST: begin
          if (free_any) begin
            vld_r[free_idx] <= 1'b1;
            arrcnt_r <= arrcnt_r + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture, request updates and output payload (no reset)
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[SW-1:0];
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_func; oid_r <= in_order_id; side_r <= in_side;
      price_r <= in_price; qty_r <= in_quantity; ts_r <= in_timestamp;
    end else if (state_r == S_FOUND && have_r && func_r == lobm_pkg::FUNC_MODIFY) begin
      // resubmit keeps the stored side, time moves on by one
      side_r <= rdata.side;
      ts_r <= rdata.ts + 48'd1;
    end else if (state_r == S_FILL && we) begin
      qty_r <= qty_r - fill;
    end
    if (ld_out) begin
      okind_r <= nk; olast_r <= nl; otid_r <= ntid; obuy_r <= nbuy; osell_r <= nsell;
      oprice_r <= nprice; oamt_r <= namt; otime_r <= ntime; ost_r <= nst;
    end
  end

  // checks
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted twice");
  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == lobm_pkg::KIND_TRADE) |-> !out_last)
    else $error("trade flagged last");
  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !we) else $error("write while idle");
  a_tradeno: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && we) |=> tradeno_r == $past(tradeno_r) + 32'd1)
    else $error("trade number skipped");
endmodule
`default_nettype wire
